@@ rtl/hqs_pkg.sv @@
package hqs_pkg;

  localparam int KEY_W        = 64;
  localparam int PAYLOAD_W    = 32;
  localparam int CAPACITY_DEF = 64;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;        // input transaction accepted this cycle
    logic sort_init;   // push the whole batch as the first range
    logic pop;         // read the top of the range stack
    logic range_load;  // latch lo and hi, fetch the pivot entry
    logic pivot_load;  // latch the pivot key, start both scan pointers
    logic scan;        // advance the scan pointers that may still move
    logic swap_a;      // first half of an entry swap
    logic swap_b;      // second half of an entry swap, step both pointers
    logic push_r;      // push the right part of a split range
    logic push_l;      // push the left part of a split range
    logic emit_mode;   // read port follows the emission index
    logic emit_start;  // rewind the emission index
    logic emit_load;   // move one sorted entry into the output register
  } hqs_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic n_lt2;
    logic sp_zero;
    logic range_trivial;
    logic i_go;
    logic j_go;
    logic i_ge_j;
    logic out_free;
    logic emit_last;
  } hqs_status_t;

endpackage

@@ rtl/hqs_in_if.sv @@
interface hqs_in_if import hqs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;
  logic                 last_item;

  modport source (output valid, key, payload, last_item, input ready);
  modport sink (input valid, key, payload, last_item, output ready);
endinterface

@@ rtl/hqs_out_if.sv @@
interface hqs_out_if import hqs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     key_out;
  logic [PAYLOAD_W-1:0] payload_out;
  logic                 last_out;
  logic                 dropped;

  modport source (output valid, key_out, payload_out, last_out, dropped, input ready);
  modport sink (input valid, key_out, payload_out, last_out, dropped, output ready);
endinterface

@@ rtl/hqs_datapath.sv @@
module hqs_datapath import hqs_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hqs_cmd_t             cmd,
  output hqs_status_t          status,
  input  logic [KEY_W-1:0]     item_key,
  input  logic [PAYLOAD_W-1:0] item_payload,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [KEY_W-1:0]     res_key,
  output logic [PAYLOAD_W-1:0] res_payload,
  output logic                 res_last,
  output logic                 res_dropped
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int STK_W = 2 * IDX_W;
  localparam int ENT_W = KEY_W + PAYLOAD_W;

  // Entry store: key in the upper bits, payload in the lower bits.
  logic [ENT_W-1:0] entry_mem [CAPACITY];
  logic [STK_W-1:0] stack_mem [CAPACITY];

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [CNT_W-1:0] sp;
  logic [IDX_W-1:0] lo, hi, i, j, k;
  logic [IDX_W-1:0] i_next, j_next, k_next;
  logic [KEY_W-1:0] pivot;
  logic [ENT_W-1:0] rdata_a, rdata_b;
  logic [STK_W-1:0] stack_rdata;

  logic             count_full;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] stk_lo, stk_hi;
  logic [IDX_W-1:0] addr_a, addr_b;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [ENT_W-1:0] wdata;
  logic             stack_room;
  logic             push_r_ok, push_l_ok;
  logic             stack_we;
  logic [STK_W-1:0] stack_wdata;
  logic [KEY_W-1:0] key_a, key_b;

  assign count_full = (count == CNT_W'(CAPACITY));
  assign last_idx   = IDX_W'(count - CNT_W'(1));
  assign stk_lo     = stack_rdata[STK_W-1:IDX_W];
  assign stk_hi     = stack_rdata[IDX_W-1:0];
  assign key_a      = rdata_a[ENT_W-1 -: KEY_W];
  assign key_b      = rdata_b[ENT_W-1 -: KEY_W];
  assign stack_room = (sp < CNT_W'(CAPACITY));
  assign push_r_ok  = (({1'b0, j} + {{IDX_W{1'b0}}, 1'b1}) < {1'b0, hi}) && stack_room;
  assign push_l_ok  = (lo < j) && stack_room;

  assign status.n_lt2         = (count < CNT_W'(2));
  assign status.sp_zero       = (sp == '0);
  assign status.range_trivial = (stk_lo >= stk_hi);
  assign status.i_go          = (i < hi) && (key_a < pivot);
  assign status.j_go          = (j > lo) && (key_b > pivot);
  assign status.i_ge_j        = (i >= j);
  assign status.out_free      = !res_valid || res_ready;
  assign status.emit_last     = (k == last_idx);

  always_comb begin
    i_next = i;
    if (cmd.pivot_load) begin
      i_next = lo;
    end else if ((cmd.scan && status.i_go) || cmd.swap_b) begin
      i_next = i + IDX_W'(1);
    end
  end

  always_comb begin
    j_next = j;
    if (cmd.pivot_load) begin
      j_next = hi;
    end else if ((cmd.scan && status.j_go) || cmd.swap_b) begin
      j_next = j - IDX_W'(1);
    end
  end

  always_comb begin
    k_next = k;
    if (cmd.emit_start || (cmd.emit_load && status.emit_last)) begin
      k_next = '0;
    end else if (cmd.emit_load) begin
      k_next = k + IDX_W'(1);
    end
  end

  always_comb begin
    if (cmd.range_load) begin
      addr_a = stk_lo;
    end else if (cmd.emit_mode) begin
      addr_a = k_next;
    end else begin
      addr_a = i_next;
    end
    addr_b = j_next;
  end

  always_comb begin
    we    = 1'b0;
    waddr = i;
    wdata = rdata_b;
    if (cmd.load && !count_full) begin
      we    = 1'b1;
      waddr = count[IDX_W-1:0];
      wdata = {item_key, item_payload};
    end else if (cmd.swap_a) begin
      we    = 1'b1;
      waddr = i;
      wdata = rdata_b;
    end else if (cmd.swap_b) begin
      we    = 1'b1;
      waddr = j;
      wdata = rdata_a;
    end
  end

  always_comb begin
    stack_we    = 1'b0;
    stack_wdata = {lo, j};
    if (cmd.sort_init) begin
      stack_we    = 1'b1;
      stack_wdata = {{IDX_W{1'b0}}, last_idx};
    end else if (cmd.push_r) begin
      stack_we    = push_r_ok;
      stack_wdata = {j + IDX_W'(1), hi};
    end else if (cmd.push_l) begin
      stack_we    = push_l_ok;
      stack_wdata = {lo, j};
    end
  end

  // Both read ports are registered; a read in the cycle of a write returns the old entry.
  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem[waddr] <= wdata;
    end
    rdata_a <= entry_mem[addr_a];
    rdata_b <= entry_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[sp[IDX_W-1:0]] <= stack_wdata;
    end
    if (cmd.pop) begin
      stack_rdata <= stack_mem[IDX_W'(sp - CNT_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      sp        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (count_full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.sort_init) begin
        sp <= CNT_W'(1);
      end else if (cmd.pop) begin
        sp <= sp - CNT_W'(1);
      end else if ((cmd.push_r && push_r_ok) || (cmd.push_l && push_l_ok)) begin
        sp <= sp + CNT_W'(1);
      end
      if (cmd.emit_load) begin
        res_valid <= 1'b1;
        if (status.emit_last) begin
          count    <= '0;
          overflow <= 1'b0;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.range_load) begin
      lo <= stk_lo;
      hi <= stk_hi;
    end
    if (cmd.pivot_load) begin
      pivot <= key_a;
    end
    i <= i_next;
    j <= j_next;
    k <= k_next;
    if (cmd.emit_load) begin
      res_key     <= key_a;
      res_payload <= rdata_a[PAYLOAD_W-1:0];
      res_last    <= status.emit_last;
      res_dropped <= overflow;
    end
  end

endmodule

@@ rtl/hqs_controller.sv @@
module hqs_controller import hqs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_last,
  output logic        item_ready,
  input  hqs_status_t status,
  output hqs_cmd_t    cmd
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_POP     = 4'd2;
  localparam logic [3:0] S_RANGE   = 4'd3;
  localparam logic [3:0] S_PIVOT   = 4'd4;
  localparam logic [3:0] S_SCAN    = 4'd5;
  localparam logic [3:0] S_SWAP_A  = 4'd6;
  localparam logic [3:0] S_SWAP_B  = 4'd7;
  localparam logic [3:0] S_REREAD  = 4'd8;
  localparam logic [3:0] S_PUSH_R  = 4'd9;
  localparam logic [3:0] S_PUSH_L  = 4'd10;
  localparam logic [3:0] S_EMIT_RD = 4'd11;
  localparam logic [3:0] S_EMIT    = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    state_next = state;
    case (state)
      S_LOAD: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          if (item_last) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (status.n_lt2) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.sort_init = 1'b1;
          state_next    = S_POP;
        end
      end
      S_POP: begin
        if (status.sp_zero) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd.range_load = 1'b1;
        state_next     = status.range_trivial ? S_POP : S_PIVOT;
      end
      S_PIVOT: begin
        cmd.pivot_load = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!status.i_go && !status.j_go) begin
          state_next = status.i_ge_j ? S_PUSH_R : S_SWAP_A;
        end
      end
      S_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.swap_b = 1'b1;
        state_next = S_REREAD;
      end
      S_REREAD: begin
        state_next = S_SCAN;
      end
      S_PUSH_R: begin
        cmd.push_r = 1'b1;
        state_next = S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd.push_l = 1'b1;
        state_next = S_POP;
      end
      S_EMIT_RD: begin
        cmd.emit_mode  = 1'b1;
        cmd.emit_start = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_mode = 1'b1;
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/hoare_quicksort_by_key_core.sv @@
// Channel   Modport  Transaction carries
// --------  -------  ----------------------------------------------------------
// entries   sink     key (64), payload (32), last_item (1): one entry to store
// results   source   key_out (64), payload_out (32), last_out (1), dropped (1)
//
// Loading accepts one entry per cycle. After the last entry the input stalls during the sort:
// a range is popped, then loaded with its pivot entry, then its pivot key is latched (a trivial
// range goes back to the pop); scan steps advance each pointer that may still move until both
// stop; a swap writes both entries in turn and then re-reads them; a split pushes the right part
// and then the left part. Emission then moves one result per cycle while the sink keeps up. Reset is
// synchronous and empties the batch; a stalled result holds the output register and emission.
module hoare_quicksort_by_key_core import hqs_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  hqs_in_if.sink    entries,
  hqs_out_if.source results
);

  // The controller sequences loading, partitioning and emission; the datapath holds
  // the entry store, the range stack, the scan pointers and the output register.
  hqs_cmd_t    cmd;
  hqs_status_t status;

  hqs_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (entries.valid),
    .item_last  (entries.last_item),
    .item_ready (entries.ready),
    .status     (status),
    .cmd        (cmd)
  );

  hqs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_key     (entries.key),
    .item_payload (entries.payload),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_key      (results.key_out),
    .res_payload  (results.payload_out),
    .res_last     (results.last_out),
    .res_dropped  (results.dropped)
  );

  // A swap always completes its second write in the following cycle.
  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.swap_a |=> cmd.swap_b)
    else $error("swap was not completed");

  // An entry is moved to the output register only when that register is free.
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> status.out_free)
    else $error("result overwritten before its transaction");

  // The range stack is never popped when empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !status.sp_zero)
    else $error("range stack underflow");

endmodule
